// ===== design/code_length_rle_bit_packer_top_assert.svh =====
// Assertion macros used by the checker file of the code length packer.
`ifndef CODE_LENGTH_RLE_BIT_PACKER_TOP_ASSERT_SVH
`define CODE_LENGTH_RLE_BIT_PACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLRBP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/clrbp_pkg.sv =====
// Package: constants and register indexes of the code length packer.
package clrbp_pkg;

    localparam int SYMBOL_BITS_DEFAULT = 5;

    localparam int CODE_W   = 5;
    localparam int COUNT_W  = 8;
    localparam int BYTE_BITS  = 8;
    localparam int BYTE_SHIFT = 3;

    localparam int ZERO_LONG_MAX = 138;
    localparam int ZERO_LONG_MIN = 11;
    localparam int REPEAT_MIN    = 3;
    localparam int COPY_MAX      = 6;

    localparam int LONG_EXTRA_BITS  = 7;
    localparam int SHORT_EXTRA_BITS = 3;
    localparam int COPY_EXTRA_BITS  = 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_PREVIOUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SHORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LONG     = 2'd2;

    localparam logic [CODE_W-1:0] COPY_PREVIOUS_RESET = 5'd16;
    localparam logic [CODE_W-1:0] ZERO_SHORT_RESET    = 5'd17;
    localparam logic [CODE_W-1:0] ZERO_LONG_RESET     = 5'd18;

endpackage

// ===== design/clrbp_in_if.sv =====
// Interface: input channel carrying one code length per transaction.
interface clrbp_in_if
    import clrbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_length;
    logic              final_length;

    modport source (output valid, code_length, final_length, input ready);
    modport sink   (input valid, code_length, final_length, output ready);
endinterface

// ===== design/clrbp_out_if.sv =====
// Interface: output channel carrying one packed byte per transaction.
interface clrbp_out_if
    import clrbp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== design/code_length_rle_bit_packer_top.sv =====
// Latency: an item is encoded in its accept cycle; its first byte is valid the next cycle.
// An item completes N bytes (0..3, up to 4 at SYMBOL_BITS 8); the byte holding register
// drains one byte per cycle to the port while the port is ready.
// Input is taken while the holding register is empty or hands off its last byte.
// Reset (async, active low): run and bit state cleared, holding register empty,
// symbol codes back to 16, 17, 18.
module code_length_rle_bit_packer_top
    import clrbp_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    clrbp_in_if.sink             lengths,
    clrbp_out_if.source          encoded,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    localparam int SB        = SYMBOL_BITS;
    localparam int SEG_W     = (2 * SB > SB + LONG_EXTRA_BITS) ? 2 * SB : SB + LONG_EXTRA_BITS;
    localparam int SEG_LW    = $clog2(SEG_W + 1);
    // held bits plus the longest bit string a single item can append
    localparam int ACC_W     = (BYTE_BITS - 1) + 3 * SB + LONG_EXTRA_BITS;
    localparam int ACC_LW    = $clog2(ACC_W + 1);
    localparam int MAX_BYTES = (ACC_W + BYTE_BITS - 1) / BYTE_BITS;
    localparam int PEND_W    = MAX_BYTES * BYTE_BITS;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    typedef logic [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [SEG_W-1:0]  val;
        logic [SEG_LW-1:0] len;
    } seg_t;

    // configuration
    logic [CODE_W-1:0] copy_code_reg;
    logic [CODE_W-1:0] zshort_code_reg;
    logic [CODE_W-1:0] zlong_code_reg;

    // run and bit state
    logic [BYTE_BITS-1:0] bit_holder_reg, bit_holder_next;
    logic [2:0]           held_cnt_reg, held_cnt_next;
    logic [CODE_W-1:0]    run_value_reg, run_value_next;
    logic [COUNT_W-1:0]   run_count_reg, run_count_next;
    logic                 run_open_reg, run_open_next;

    // byte holding register
    logic [PEND_W-1:0] pend_word_reg, pend_word_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;
    logic              pend_last_reg;

    logic              in_accept;
    logic              out_accept;
    logic [CODE_W-1:0] v;
    logic              fin;
    seg_t              seg1, seg2, seg3;
    acc_t              acc;
    logic [ACC_LW-1:0] total;
    logic [2:0]        lo;

    function automatic logic [SB-1:0] sym(input logic [CODE_W-1:0] c);
        logic [SB+CODE_W-1:0] ext;
        ext = {{SB{1'b0}}, c};
        return ext[SB-1:0];
    endfunction

    function automatic seg_t close_seg(
        input logic [CODE_W-1:0]  rv,
        input logic [COUNT_W-1:0] c,
        input logic [CODE_W-1:0]  cp,
        input logic [CODE_W-1:0]  zs,
        input logic [CODE_W-1:0]  zl
    );
        seg_t s;
        s = '0;
        if (rv == '0)
        begin
            if (c >= ZERO_LONG_MIN)
            begin
                s.val = SEG_W'({sym(zl), LONG_EXTRA_BITS'(c - ZERO_LONG_MIN)});
                s.len = SEG_LW'(SB + LONG_EXTRA_BITS);
            end
            else if (c >= REPEAT_MIN)
            begin
                s.val = SEG_W'({sym(zs), SHORT_EXTRA_BITS'(c - REPEAT_MIN)});
                s.len = SEG_LW'(SB + SHORT_EXTRA_BITS);
            end
            else
            begin
                // one or two literal zeros
                s.len = (c == COUNT_W'(2)) ? SEG_LW'(2 * SB) :
                        (c == COUNT_W'(1)) ? SEG_LW'(SB) : '0;
            end
        end
        else
        begin
            if (c >= REPEAT_MIN)
            begin
                s.val = SEG_W'({sym(cp), COPY_EXTRA_BITS'(c - REPEAT_MIN)});
                s.len = SEG_LW'(SB + COPY_EXTRA_BITS);
            end
            else if (c == COUNT_W'(2))
            begin
                s.val = SEG_W'({sym(rv), sym(rv)});
                s.len = SEG_LW'(2 * SB);
            end
            else if (c == COUNT_W'(1))
            begin
                s.val = SEG_W'(sym(rv));
                s.len = SEG_LW'(SB);
            end
        end
        return s;
    endfunction

    function automatic acc_t app(input acc_t a, input seg_t s);
        return (a << s.len) | ACC_W'(s.val);
    endfunction

    assign in_accept  = lengths.valid & lengths.ready;
    assign out_accept = encoded.valid & encoded.ready;

    assign lengths.ready    = (pend_cnt_reg == '0) ||
                              ((pend_cnt_reg == CNT_W'(1)) && encoded.ready);
    assign encoded.valid    = (pend_cnt_reg != '0);
    assign encoded.out_byte = pend_word_reg[PEND_W-1 -: BYTE_BITS];
    assign encoded.last_byte = pend_last_reg && (pend_cnt_reg == CNT_W'(1));

    assign v   = lengths.code_length;
    assign fin = lengths.final_length;

    always_comb
    begin
        seg1 = '0;
        seg2 = '0;
        seg3 = '0;
        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        run_open_next  = run_open_reg;

        if (run_open_reg && (v == run_value_reg))
        begin
            if (v == '0)
            begin
                if (run_count_reg >= ZERO_LONG_MAX)
                begin
                    seg1.val = SEG_W'({sym(zlong_code_reg),
                                       LONG_EXTRA_BITS'(ZERO_LONG_MAX - ZERO_LONG_MIN)});
                    seg1.len = SEG_LW'(SB + LONG_EXTRA_BITS);
                    run_count_next = COUNT_W'(1);
                end
                else
                begin
                    run_count_next = run_count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                if (run_count_reg >= COPY_MAX)
                begin
                    seg1.val = SEG_W'({sym(copy_code_reg),
                                       COPY_EXTRA_BITS'(COPY_MAX - REPEAT_MIN)});
                    seg1.len = SEG_LW'(SB + COPY_EXTRA_BITS);
                    run_count_next = COUNT_W'(1);
                end
                else
                begin
                    run_count_next = run_count_reg + COUNT_W'(1);
                end
            end
        end
        else
        begin
            if (run_open_reg)
            begin
                seg1 = close_seg(run_value_reg, run_count_reg,
                                 copy_code_reg, zshort_code_reg, zlong_code_reg);
            end
            run_open_next  = 1'b1;
            run_value_next = v;
            if (v == '0)
            begin
                run_count_next = COUNT_W'(1);
            end
            else
            begin
                seg2.val = SEG_W'(sym(v));
                seg2.len = SEG_LW'(SB);
                run_count_next = '0;
            end
        end

        if (fin)
        begin
            seg3 = close_seg(run_value_next, run_count_next,
                             copy_code_reg, zshort_code_reg, zlong_code_reg);
        end

        // held bits right-aligned, then the new symbols appended below them
        acc   = ACC_W'(bit_holder_reg >> (BYTE_BITS - held_cnt_reg));
        acc   = app(app(app(acc, seg1), seg2), seg3);
        total = ACC_LW'(held_cnt_reg) + ACC_LW'(seg1.len) + ACC_LW'(seg2.len)
              + ACC_LW'(seg3.len);
        lo    = total[BYTE_SHIFT-1:0];

        pend_word_next = PEND_W'(acc) << (PEND_W - total);
        pend_cnt_next  = CNT_W'(total >> BYTE_SHIFT);

        if (fin)
        begin
            // flush the partial byte zero-padded, clear the run
            pend_cnt_next   = pend_cnt_next + CNT_W'(lo != '0);
            bit_holder_next = '0;
            held_cnt_next   = '0;
            run_value_next  = '0;
            run_count_next  = '0;
            run_open_next   = 1'b0;
        end
        else
        begin
            bit_holder_next = BYTE_BITS'(acc[BYTE_BITS-1:0] << (BYTE_BITS - lo));
            held_cnt_next   = lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_holder_reg <= '0;
            held_cnt_reg   <= '0;
            run_value_reg  <= '0;
            run_count_reg  <= '0;
            run_open_reg   <= 1'b0;
            pend_word_reg  <= '0;
            pend_cnt_reg   <= '0;
            pend_last_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            bit_holder_reg <= bit_holder_next;
            held_cnt_reg   <= held_cnt_next;
            run_value_reg  <= run_value_next;
            run_count_reg  <= run_count_next;
            run_open_reg   <= run_open_next;
            pend_word_reg  <= pend_word_next;
            pend_cnt_reg   <= pend_cnt_next;
            pend_last_reg  <= fin;
        end
        else if (out_accept)
        begin
            pend_word_reg <= pend_word_reg << BYTE_BITS;
            pend_cnt_reg  <= pend_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_code_reg   <= COPY_PREVIOUS_RESET;
            zshort_code_reg <= ZERO_SHORT_RESET;
            zlong_code_reg  <= ZERO_LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COPY_PREVIOUS: copy_code_reg   <= cfg_data;
                CFG_ZERO_SHORT:    zshort_code_reg <= cfg_data;
                CFG_ZERO_LONG:     zlong_code_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

// ===== design/clrbp_checker.sv =====
// Port-level checker for the code length packer, bound to the top level.
`include "code_length_rle_bit_packer_top_assert.svh"

module clrbp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_final,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);

    `CLRBP_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output valid dropped while stalled")
    `CLRBP_ASSERT_NEXT(a_final_gives_byte, clk, rst_n, in_valid && in_ready && in_final, out_valid, "final length produced no byte")
    `CLRBP_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")
    `CLRBP_ASSERT_SAME(a_last_with_valid, clk, rst_n, out_last, out_valid, "last byte flag without valid byte")

endmodule

bind code_length_rle_bit_packer_top clrbp_checker u_clrbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lengths.valid),
    .in_ready  (lengths.ready),
    .in_final  (lengths.final_length),
    .out_valid (encoded.valid),
    .out_ready (encoded.ready),
    .out_last  (encoded.last_byte)
);

// ===== tb/sv/code_length_rle_bit_packer_top_tb.sv =====
// Self-checking testbench: code length run-length encoder and MSB-first bit packer.
`timescale 1ns / 1ps

module code_length_rle_bit_packer_top_tb;
    import clrbp_pkg::*;

    localparam int SYM_BITS        = SYMBOL_BITS_DEFAULT;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int PHASE_ITEMS     = 40;
    localparam int DIRECTED_ROWS   = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic                 fin;
        logic                 typed;
        logic [BYTE_BITS-1:0] typed_byte;
    } length_row_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } packed_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CODE_W-1:0]    cfg_data;

    clrbp_in_if  lengths_if ();
    clrbp_out_if encoded_if ();

    code_length_rle_bit_packer_top #(
        .SYMBOL_BITS(SYM_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .lengths(lengths_if),
        .encoded(encoded_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // symbol registers and run/bit state as the encoder should hold them
    logic [CODE_W-1:0]    copy_sym;
    logic [CODE_W-1:0]    zshort_sym;
    logic [CODE_W-1:0]    zlong_sym;
    logic [BYTE_BITS-1:0] pack_reg;
    int                   pack_fill;
    logic [CODE_W-1:0]    run_code;
    int                   run_tally;
    logic                 run_live;

    packed_byte_t bytes_due[$];
    packed_byte_t oldest;

    int fail_count        = 0;
    int items_sent        = 0;
    int cycle_count       = 0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int hold_off_requests = 0;
    int hold_off_served   = 0;
    int stall_left        = 0;

    // rows marked typed carry the byte that is obvious by hand; it replaces the prediction
    length_row_t directed_rows [DIRECTED_ROWS] = '{
        '{5'd31, 1'b1, 1'b1, 8'hF8},   // widest literal alone, padded
        '{5'd0,  1'b1, 1'b1, 8'h00},   // lone zero
        '{5'd1,  1'b1, 1'b1, 8'h08},
        '{5'd0,  1'b0, 1'b0, 8'h00},   // shortest repeat-zero run
        '{5'd0,  1'b0, 1'b0, 8'h00},
        '{5'd0,  1'b1, 1'b1, 8'h88},
        '{5'd7,  1'b0, 1'b0, 8'h00},   // literal, then a full copy chunk and one more
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd7,  1'b0, 1'b0, 8'h00},
        '{5'd0,  1'b0, 1'b0, 8'h00},   // two zeros go out as literals
        '{5'd0,  1'b0, 1'b0, 8'h00},
        '{5'd5,  1'b0, 1'b0, 8'h00},   // two repeats go out as literals
        '{5'd5,  1'b0, 1'b0, 8'h00},
        '{5'd5,  1'b0, 1'b0, 8'h00},
        '{5'd31, 1'b0, 1'b0, 8'h00},
        '{5'd9,  1'b0, 1'b0, 8'h00},   // copy run closed by the final flag
        '{5'd9,  1'b0, 1'b0, 8'h00},
        '{5'd9,  1'b0, 1'b0, 8'h00},
        '{5'd9,  1'b1, 1'b0, 8'h00},
        '{5'd16, 1'b1, 1'b0, 8'h00}
    };

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still due", $time, bytes_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // output side: check each transaction, then decide ready for the next edge
    always @(posedge clk) begin
        if (encoded_if.valid && encoded_if.ready) begin
            if (bytes_due.size() == 0) begin
                $display("%0t: byte %h last %b arrived with none due", $time,
                         encoded_if.out_byte, encoded_if.last_byte);
                fail_count++;
            end
            else begin
                oldest = bytes_due.pop_front();
                if (encoded_if.out_byte !== oldest.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             oldest.data, encoded_if.out_byte);
                    fail_count++;
                end
                if (encoded_if.last_byte !== oldest.last) begin
                    $display("%0t: last_byte expected %b actual %b", $time,
                             oldest.last, encoded_if.last_byte);
                    fail_count++;
                end
            end
        end
        if (!rst_n) begin
            encoded_if.ready <= 1'b0;
        end
        else if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            stall_left      = HOLD_OFF_CYCLES;
            encoded_if.ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            encoded_if.ready <= 1'b0;
        end
        else begin
            encoded_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // appends one expected byte at the tail of the queue
    function automatic void queue_byte(input packed_byte_t b);
        bytes_due.insert(bytes_due.size(), b);
    endfunction

    function automatic void put_bits(input int value, input int width);
        for (int i = width - 1; i >= 0; i--) begin
            if ((value >> i) & 1)
                pack_reg[BYTE_BITS - 1 - pack_fill] = 1'b1;
            pack_fill++;
            if (pack_fill == BYTE_BITS) begin
                queue_byte('{pack_reg, 1'b0});
                pack_reg  = '0;
                pack_fill = 0;
            end
        end
    endfunction

    function automatic void put_symbol(input logic [CODE_W-1:0] sym);
        put_bits(int'(sym) & ((1 << SYM_BITS) - 1), SYM_BITS);
    endfunction

    function automatic void close_run();
        if (!run_live)
            return;
        if (run_code == '0) begin
            if (run_tally >= ZERO_LONG_MIN) begin
                put_symbol(zlong_sym);
                put_bits(run_tally - ZERO_LONG_MIN, LONG_EXTRA_BITS);
            end
            else if (run_tally >= REPEAT_MIN) begin
                put_symbol(zshort_sym);
                put_bits(run_tally - REPEAT_MIN, SHORT_EXTRA_BITS);
            end
            else begin
                for (int k = 0; k < run_tally; k++)
                    put_symbol('0);
            end
        end
        else begin
            if (run_tally >= REPEAT_MIN) begin
                put_symbol(copy_sym);
                put_bits(run_tally - REPEAT_MIN, COPY_EXTRA_BITS);
            end
            else begin
                for (int k = 0; k < run_tally; k++)
                    put_symbol(run_code);
            end
        end
        run_live  = 1'b0;
        run_tally = 0;
    endfunction

    // queues the bytes one length releases; returns how many
    function automatic int encode_length(input logic [CODE_W-1:0] code, input logic fin);
        int queued_at_entry;
        queued_at_entry = bytes_due.size();
        if (run_live && code == run_code) begin
            if (code == '0) begin
                if (run_tally >= ZERO_LONG_MAX) begin
                    put_symbol(zlong_sym);
                    put_bits(ZERO_LONG_MAX - ZERO_LONG_MIN, LONG_EXTRA_BITS);
                    run_tally = 1;
                end
                else begin
                    run_tally++;
                end
            end
            else begin
                if (run_tally >= COPY_MAX) begin
                    put_symbol(copy_sym);
                    put_bits(COPY_MAX - REPEAT_MIN, COPY_EXTRA_BITS);
                    run_tally = 1;
                end
                else begin
                    run_tally++;
                end
            end
        end
        else begin
            close_run();
            run_live = 1'b1;
            run_code = code;
            if (code == '0) begin
                run_tally = 1;
            end
            else begin
                put_symbol(code);
                run_tally = 0;
            end
        end
        if (fin) begin
            close_run();
            if (pack_fill > 0)
                queue_byte('{pack_reg, 1'b0});
            if (bytes_due.size() > queued_at_entry)
                bytes_due[bytes_due.size() - 1].last = 1'b1;
            pack_reg  = '0;
            pack_fill = 0;
            run_code  = '0;
            run_tally = 0;
            run_live  = 1'b0;
        end
        return bytes_due.size() - queued_at_entry;
    endfunction

    task automatic send_length(input logic [CODE_W-1:0] code, input logic fin,
                               output int added);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            lengths_if.valid <= 1'b0;
            @(posedge clk);
        end
        lengths_if.valid        <= 1'b1;
        lengths_if.code_length  <= code;
        lengths_if.final_length <= fin;
        do
            @(posedge clk);
        while (!(lengths_if.valid && lengths_if.ready));
        items_sent++;
        added = encode_length(code, fin);
    endtask

    // a table of runs ending on the final flag, with a few stray lengths mixed in
    task automatic send_random_table(input bit with_long_zero_run);
        int runs;
        int run_len;
        int pick;
        int added;
        logic [CODE_W-1:0] value;
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++) begin
            pick = $urandom_range(0, 99);
            if (r == 0 && with_long_zero_run) begin
                value   = '0;
                run_len = $urandom_range(139, 150);
            end
            else if (pick < 45) begin
                value = '0;
                pick  = $urandom_range(0, 99);
                if (pick < 2)
                    run_len = $urandom_range(270, 290);
                else if (pick < 5)
                    run_len = $urandom_range(130, 150);
                else if (pick < 25)
                    run_len = $urandom_range(11, 40);
                else
                    run_len = $urandom_range(1, 10);
            end
            else begin
                value = CODE_W'($urandom_range(1, 31));
                if ($urandom_range(0, 99) < 20)
                    run_len = $urandom_range(11, 20);
                else
                    run_len = $urandom_range(1, 10);
            end
            for (int j = 0; j < run_len; j++) begin
                // stray length; its flag may end the table early
                if ($urandom_range(0, 99) < 6)
                    send_length(CODE_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                                added);
                send_length(value, (r == runs - 1) && (j == run_len - 1), added);
            end
        end
    endtask

    task automatic run_phase(input int target, input bit with_long_zero_run);
        int start_count;
        start_count = items_sent;
        send_random_table(with_long_zero_run);
        while (items_sent - start_count < target)
            send_random_table(1'b0);
    endtask

    task automatic drain_bytes(input int settle);
        lengths_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic program_codes(input logic [CODE_W-1:0] copy_code,
                                 input logic [CODE_W-1:0] zshort,
                                 input logic [CODE_W-1:0] zlong);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COPY_PREVIOUS;
        cfg_data  <= copy_code;
        @(posedge clk);
        cfg_index <= CFG_ZERO_SHORT;
        cfg_data  <= zshort;
        @(posedge clk);
        cfg_index <= CFG_ZERO_LONG;
        cfg_data  <= zlong;
        @(posedge clk);
        // no register behind this index, the write must change nothing
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CODE_W'($urandom);
        @(posedge clk);
        cfg_we     <= 1'b0;
        copy_sym   = copy_code;
        zshort_sym = zshort;
        zlong_sym  = zlong;
    endtask

    initial begin
        int added;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_COPY_PREVIOUS;
        cfg_data                = '0;
        lengths_if.valid        = 1'b0;
        lengths_if.code_length  = '0;
        lengths_if.final_length = 1'b0;
        copy_sym                = COPY_PREVIOUS_RESET;
        zshort_sym              = ZERO_SHORT_RESET;
        zlong_sym               = ZERO_LONG_RESET;
        pack_reg                = '0;
        pack_fill               = 0;
        run_code                = '0;
        run_tally               = 0;
        run_live                = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_length(directed_rows[r].code, directed_rows[r].fin, added);
            if (directed_rows[r].typed) begin
                repeat (added) void'(bytes_due.pop_back());
                queue_byte('{directed_rows[r].typed_byte, 1'b1});
            end
        end

        drain_bytes(SETTLE_CYCLES);
        program_codes('0, '0, '0);
        run_phase(PHASE_ITEMS, 1'b1);

        drain_bytes(SETTLE_CYCLES);
        program_codes('1, '1, '1);
        send_idle_pct  = 58;
        recv_stall_pct = 0;
        run_phase(PHASE_ITEMS, 1'b0);

        drain_bytes(SETTLE_CYCLES);
        program_codes(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        // long receiver hold-off while lengths keep coming: input must back up
        hold_off_requests++;
        run_phase(PHASE_ITEMS, 1'b0);

        drain_bytes(SETTLE_CYCLES);
        program_codes(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_phase(PHASE_ITEMS / 2, 1'b0);
        drain_bytes(0);
        run_phase(PHASE_ITEMS / 2, 1'b0);

        drain_bytes(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
